// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files; the calibrator core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge once out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcoc_pkg.sv =====
// Shared constants and types for the phase current offset calibrator.
`default_nettype none

package pcoc_pkg;

    localparam int unsigned RAW_W      = 12;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned CUR_W      = 15;
    localparam int unsigned SUM_W      = 20;
    localparam int unsigned TICK_W     = 8;

    // Calibration run length, 1 to 255 ticks.
    localparam int unsigned CAL_SAMPLES = 25;

    // Exact divide by CAL_SAMPLES for any SUM_W-bit sum: q = (x * CAL_RECIP) >> CAL_SHIFT.
    localparam int unsigned RECIP_W    = SUM_W + 1;
    localparam int unsigned CAL_SHIFT  = SUM_W + $clog2(CAL_SAMPLES);
    localparam longint unsigned CAL_RECIP_L =
        ((64'd1 << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam logic [RECIP_W-1:0] CAL_RECIP = RECIP_W'(CAL_RECIP_L);
    localparam logic [TICK_W-1:0]  CAL_LAST  = TICK_W'(CAL_SAMPLES - 1);

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1719;

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // APB register map
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_CURRENT_GAIN = 3'd0;

    // Per-phase control from the top level
    typedef struct packed {
        logic sample;    // sample transaction leaves stage 1
        logic accum;     // tick with motor stopped: add latest raw to sum
        logic cal_done;  // last tick of a run: load offset, clear sum
    } t_phase_ctrl;

endpackage

`default_nettype wire

// ===== rtl/pcoc_phase.sv =====
// One phase: latest raw, offset learning and raw-to-milliamp conversion.
`default_nettype none

module pcoc_phase (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire pcoc_pkg::t_phase_ctrl   i_ctrl,
    input  wire [pcoc_pkg::RAW_W-1:0]    i_raw,
    input  wire [pcoc_pkg::GAIN_W-1:0]   i_gain,
    output logic [pcoc_pkg::CUR_W-1:0]   o_current
);
    import pcoc_pkg::*;

    localparam int unsigned MUL_W  = RAW_W + GAIN_W;
    localparam int unsigned SCL_W  = MUL_W + 1 - 8;
    localparam int unsigned PROD_W = SUM_W + RECIP_W;

    logic [RAW_W-1:0]  r_latest, n_latest;
    logic [SUM_W-1:0]  r_sum,    n_sum;
    logic [RAW_W-1:0]  r_offset, n_offset;

    logic [RAW_W-1:0]  diff;
    logic [MUL_W-1:0]  mul;
    logic [MUL_W:0]    rnd;
    logic [SCL_W-1:0]  scaled;
    logic [SUM_W-1:0]  sum_inc;
    logic [PROD_W-1:0] quo_prod;
    logic [PROD_W-1:0] quo;

    // Conversion: clamp negative difference, Q8.8 gain, round half up, saturate.
    always_comb begin
        diff   = (i_raw > r_offset) ? (i_raw - r_offset) : '0;
        mul    = MUL_W'(diff) * MUL_W'(i_gain);
        rnd    = {1'b0, mul} + (MUL_W+1)'(128);
        scaled = rnd[MUL_W:8];
        if (|scaled[SCL_W-1:CUR_W]) begin
            o_current = '1;
        end else begin
            o_current = scaled[CUR_W-1:0];
        end
    end

    // Offset learning
    always_comb begin
        sum_inc  = r_sum + SUM_W'(r_latest);
        quo_prod = PROD_W'(sum_inc) * PROD_W'(CAL_RECIP);
        quo      = quo_prod >> CAL_SHIFT;
        n_latest = i_ctrl.sample ? i_raw : r_latest;
        n_sum    = r_sum;
        n_offset = r_offset;
        if (i_ctrl.accum) begin
            if (i_ctrl.cal_done) begin
                n_sum    = '0;
                n_offset = quo[RAW_W-1:0];
            end else begin
                n_sum    = sum_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latest <= '0;
            r_sum    <= '0;
            r_offset <= '0;
        end else begin
            r_latest <= n_latest;
            r_sum    <= n_sum;
            r_offset <= n_offset;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/phase_current_offset_calibrator_core.sv =====
// Top level of the three-phase current sense offset calibrator.
`default_nettype none

// Converts three-phase 12-bit current-sense ADC counts to milliamps with a
// learned per-phase zero-current offset removed. A sample transaction
// (cmd = 0) updates the latest raw counts and yields one result:
// min(32767, (max(0, raw - offset) * current_gain + 128) >> 8) per phase.
// A calibration tick (cmd = 1) with motor_stopped high adds the latest raw
// counts into per-phase sums; after CAL_SAMPLES such ticks each offset
// becomes sum / CAL_SAMPLES (truncated) and a new run starts. Ticks with the
// motor running are dropped and leave the run as is. Ticks never yield a
// result. Throughput is one transaction per clock but for the back-pressure
// below; an accepted input passes the input register, then the result
// register, with the single 12x16 multiply per phase between them.
// A result waiting under output stall does not block the input register
// from taking the next transaction; back-pressure reaches the input only
// when a sample sits in stage 1 behind a stalled result. current_gain sits
// at APB byte address 0 (16 bits, reset 1719, unsigned Q8.8 mA/count) and
// must only be written while the block is idle.
module phase_current_offset_calibrator_core (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // APB configuration
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [pcoc_pkg::PADDR_W-1:0]   paddr,
    input  wire [pcoc_pkg::PDATA_W-1:0]   pwdata,
    output logic [pcoc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // input channel
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire                           i_cmd,
    input  wire [pcoc_pkg::RAW_W-1:0]     i_raw_u,
    input  wire [pcoc_pkg::RAW_W-1:0]     i_raw_v,
    input  wire [pcoc_pkg::RAW_W-1:0]     i_raw_w,
    input  wire                           i_motor_stopped,
    // output channel
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic [pcoc_pkg::CUR_W-1:0]    o_current_u,
    output logic [pcoc_pkg::CUR_W-1:0]    o_current_v,
    output logic [pcoc_pkg::CUR_W-1:0]    o_current_w
);
    import pcoc_pkg::*;

    `include "assert_macros.svh"

    // ---------------- configuration ----------------
    logic [GAIN_W-1:0] r_gain, n_gain;
    logic              gain_sel;
    logic              cfg_wr;

    assign pready   = 1'b1;
    assign gain_sel = (paddr == ADDR_CURRENT_GAIN);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign n_gain   = (cfg_wr && gain_sel) ? pwdata[GAIN_W-1:0] : r_gain;
    assign prdata   = gain_sel ? PDATA_W'(r_gain) : '0;

    // ---------------- stage 1: input register ----------------
    logic             r_s1_valid, n_s1_valid;
    logic             r_s1_cmd;
    logic             r_s1_stopped;
    logic [RAW_W-1:0] r_s1_raw_u, r_s1_raw_v, r_s1_raw_w;
    logic             in_accept;
    logic             s1_adv;

    // Ticks retire without touching the output register; samples need it
    // to be empty or draining this cycle.
    assign s1_adv     = r_s1_valid &&
                        (r_s1_cmd == CMD_TICK || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    // ---------------- calibration run counter ----------------
    logic [TICK_W-1:0] r_tick_count, n_tick_count;
    t_phase_ctrl       ctrl;

    always_comb begin
        ctrl.sample   = s1_adv && (r_s1_cmd == CMD_SAMPLE);
        ctrl.accum    = s1_adv && (r_s1_cmd == CMD_TICK) && r_s1_stopped;
        ctrl.cal_done = ctrl.accum && (r_tick_count == CAL_LAST);
        n_tick_count  = r_tick_count;
        if (ctrl.accum) begin
            n_tick_count = ctrl.cal_done ? '0 : r_tick_count + 1'b1;
        end
    end

    // ---------------- per-phase datapath ----------------
    logic [CUR_W-1:0] cur_u, cur_v, cur_w;

    pcoc_phase u_phase_u (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_raw     (r_s1_raw_u),
        .i_gain    (r_gain),
        .o_current (cur_u)
    );

    pcoc_phase u_phase_v (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_raw     (r_s1_raw_v),
        .i_gain    (r_gain),
        .o_current (cur_v)
    );

    pcoc_phase u_phase_w (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_raw     (r_s1_raw_w),
        .i_gain    (r_gain),
        .o_current (cur_w)
    );

    // ---------------- result register ----------------
    logic r_out_valid, n_out_valid;

    always_comb begin
        n_out_valid = r_out_valid;
        if (ctrl.sample) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= GAIN_RESET;
            r_s1_valid   <= 1'b0;
            r_tick_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_gain       <= n_gain;
            r_s1_valid   <= n_s1_valid;
            r_tick_count <= n_tick_count;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd     <= i_cmd;
            r_s1_stopped <= i_motor_stopped;
            r_s1_raw_u   <= i_raw_u;
            r_s1_raw_v   <= i_raw_v;
            r_s1_raw_w   <= i_raw_w;
        end
        if (ctrl.sample) begin
            o_current_u  <= cur_u;
            o_current_v  <= cur_v;
            o_current_w  <= cur_w;
        end
    end

    // ---------------- assertions ----------------
    `ASSERT_ALWAYS(a_tick_range, i_clk, i_rst_n, r_tick_count <= CAL_LAST,
        "tick count ran past the calibration run length")
    `ASSERT_IMPLY(a_sample_blocks, i_clk, i_rst_n,
        r_s1_valid && r_s1_cmd == CMD_SAMPLE && r_out_valid && i_out_stall,
        o_in_stall, "sample behind a stalled result did not stall the input")
    `ASSERT_NEXT(a_tick_no_result, i_clk, i_rst_n,
        r_s1_valid && r_s1_cmd == CMD_TICK && !r_out_valid, !r_out_valid,
        "calibration tick produced a result")

endmodule

`default_nettype wire

// ===== tb/pcoc_current_checker.sv =====
// Checker for the phase current offset calibrator: predicts results and compares them.
`default_nettype none

module pcoc_current_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [pcoc_pkg::PADDR_W-1:0]   paddr,
    input  wire [pcoc_pkg::PDATA_W-1:0]   pwdata,
    input  wire [pcoc_pkg::PDATA_W-1:0]   prdata,
    input  wire                           pready,
    input  wire                           i_in_valid,
    input  wire                           o_in_stall,
    input  wire                           i_cmd,
    input  wire [pcoc_pkg::RAW_W-1:0]     i_raw_u,
    input  wire [pcoc_pkg::RAW_W-1:0]     i_raw_v,
    input  wire [pcoc_pkg::RAW_W-1:0]     i_raw_w,
    input  wire                           i_motor_stopped,
    input  wire                           o_out_valid,
    input  wire                           i_out_stall,
    input  wire [pcoc_pkg::CUR_W-1:0]     o_current_u,
    input  wire [pcoc_pkg::CUR_W-1:0]     o_current_v,
    input  wire [pcoc_pkg::CUR_W-1:0]     o_current_w,
    output int                            o_fail_count,
    output int                            o_pending
);
    import pcoc_pkg::*;

    typedef logic [2:0][CUR_W-1:0] t_phase_currents;

    logic [GAIN_W-1:0] gain_q;
    logic [RAW_W-1:0]  last_raw     [3];
    logic [SUM_W-1:0]  raw_sum      [3];
    logic [TICK_W-1:0] ticks_in_run;
    logic [RAW_W-1:0]  learned_off  [3];
    t_phase_currents   expected_currents [$];
    string             phase_name   [3] = '{"current_u", "current_v", "current_w"};

    // Offset-corrected count scaled by the Q8.8 gain, rounded, saturated.
    function automatic logic [CUR_W-1:0] to_milliamps(input logic [RAW_W-1:0] raw,
                                                      input logic [RAW_W-1:0] off);
        logic [31:0] scaled;
        if (raw <= off) return '0;
        scaled = ((32'(raw) - 32'(off)) * 32'(gain_q) + 32'd128) >> 8;
        if (scaled > 32'd32767) return {CUR_W{1'b1}};
        return scaled[CUR_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_phase_currents got, want;
        if (!i_rst_n) begin
            gain_q = GAIN_RESET;
            ticks_in_run = '0;
            for (int p = 0; p < 3; p++) begin
                last_raw[p] = '0;
                raw_sum[p] = '0;
                learned_off[p] = '0;
            end
            expected_currents.delete();
        end else begin
            if (psel && penable && pready && paddr == ADDR_CURRENT_GAIN) begin
                if (pwrite) begin
                    gain_q = pwdata[GAIN_W-1:0];
                end else if (prdata !== PDATA_W'(gain_q)) begin
                    $error("prdata: expected %0d, got %0d", gain_q, prdata);
                    o_fail_count++;
                end
            end

            // Retire first so a transaction accepted on the same edge is never matched.
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got = {o_current_w, o_current_v, o_current_u};
                if (expected_currents.size() == 0) begin
                    $error("unexpected result: %0d %0d %0d", got[0], got[1], got[2]);
                    o_fail_count++;
                end else begin
                    want = expected_currents.pop_front();
                    for (int p = 0; p < 3; p++) begin
                        if (got[p] !== want[p]) begin
                            $error("%s: expected %0d, got %0d", phase_name[p], want[p], got[p]);
                            o_fail_count++;
                        end
                    end
                end
            end

            if (i_in_valid === 1'b1 && o_in_stall === 1'b0) begin
                if (i_cmd == CMD_SAMPLE) begin
                    last_raw[0] = i_raw_u;
                    last_raw[1] = i_raw_v;
                    last_raw[2] = i_raw_w;
                    for (int p = 0; p < 3; p++)
                        want[p] = to_milliamps(last_raw[p], learned_off[p]);
                    expected_currents.push_back(want);
                end else if (i_motor_stopped) begin
                    for (int p = 0; p < 3; p++)
                        raw_sum[p] = raw_sum[p] + SUM_W'(last_raw[p]);
                    ticks_in_run = ticks_in_run + 1'b1;
                    if (ticks_in_run >= TICK_W'(CAL_SAMPLES)) begin
                        for (int p = 0; p < 3; p++) begin
                            learned_off[p] = RAW_W'(raw_sum[p] / SUM_W'(CAL_SAMPLES));
                            raw_sum[p] = '0;
                        end
                        ticks_in_run = '0;
                    end
                end
            end
        end
        o_pending = expected_currents.size();
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the calibrator testbench: clock, reset, stimulus, back-pressure and verdict.
`default_nettype none

module testbench;
    import pcoc_pkg::*;

    // Cycles without any accepted transaction before the run is declared hung.
    localparam int IDLE_LIMIT = 2000;
    // Pipeline settling margin before register writes.
    localparam int SETTLE_CYCLES = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_cmd;
    logic [RAW_W-1:0]     i_raw_u;
    logic [RAW_W-1:0]     i_raw_v;
    logic [RAW_W-1:0]     i_raw_w;
    logic                 i_motor_stopped;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [CUR_W-1:0]     o_current_u;
    logic [CUR_W-1:0]     o_current_v;
    logic [CUR_W-1:0]     o_current_w;

    int fail_count;
    int results_pending;
    int items_sent;     // input transactions accepted so far
    int idle_cycles;
    bit gaps_on;        // off for stretches of back-to-back transactions
    int center_u, center_v, center_w;  // rough current offset the samples hover around

    always #2 i_clk = ~i_clk;

    phase_current_offset_calibrator_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_raw_u         (i_raw_u),
        .i_raw_v         (i_raw_v),
        .i_raw_w         (i_raw_w),
        .i_motor_stopped (i_motor_stopped),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_current_u     (o_current_u),
        .o_current_v     (o_current_v),
        .o_current_w     (o_current_w)
    );

    pcoc_current_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_raw_u         (i_raw_u),
        .i_raw_v         (i_raw_v),
        .i_raw_w         (i_raw_w),
        .i_motor_stopped (i_motor_stopped),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_current_u     (o_current_u),
        .o_current_v     (o_current_v),
        .o_current_w     (o_current_w),
        .o_fail_count    (fail_count),
        .o_pending       (results_pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Raw count: near the offset (so the clamp at zero gets both sides),
    // exactly on it, at the rails, or anywhere.
    function automatic logic [RAW_W-1:0] pick_raw(input int center);
        int r, v;
        r = $urandom_range(0, 99);
        if (r < 25) return RAW_W'($urandom_range(0, 4095));
        if (r < 35) return ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000;
        if (r < 40) return RAW_W'(center);
        v = center + $urandom_range(0, 80) - 40;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return RAW_W'(v);
    endfunction

    // One input transaction, preceded by an optional gap; returns on the accepting edge.
    task automatic send_item(input logic cmd, input logic [RAW_W-1:0] u,
                             input logic [RAW_W-1:0] v, input logic [RAW_W-1:0] w,
                             input logic stopped);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_raw_u         <= u;
        i_raw_v         <= v;
        i_raw_w         <= w;
        i_motor_stopped <= stopped;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_random_item();
        send_item(logic'($urandom_range(0, 1)), RAW_W'($urandom), RAW_W'($urandom),
                  RAW_W'($urandom), logic'($urandom_range(0, 1)));
    endtask

    // Hold the sender until every result is out. Pending is read on the falling
    // edge, after the checker has seen the rising one; returns on a rising edge.
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (results_pending != 0) @(negedge i_clk);
        repeat (settle + 1) @(posedge i_clk);
    endtask

    // Gain write followed by a read-back; the checker verifies prdata.
    task automatic write_gain(input logic [GAIN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CURRENT_GAIN;
        pwdata  <= {16'($urandom), value};  // upper bits are not part of the register
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Output back-pressure: free runs (sometimes long) broken by stalls,
    // mostly short ones.
    initial begin
        int r, n;
        forever begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
            i_out_stall <= 1'b0;
            repeat (n) @(posedge i_clk);
            r = $urandom_range(0, 99);
            n = (r < 75) ? $urandom_range(1, 3) :
                (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 40);
            i_out_stall <= 1'b1;
            repeat (n) @(posedge i_clk);
        end
    end

    // Hang detector: any accepted transaction on either channel or the APB resets it.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("** phase_current_offset_calibrator_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [GAIN_W-1:0] gain_steps [6] = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0100,
                                              16'h0000, GAIN_RESET};
        int phase_end, act, n;
        int base_u, base_v, base_w;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_in_valid      <= 1'b0;
        i_cmd           <= CMD_SAMPLE;
        i_raw_u         <= '0;
        i_raw_v         <= '0;
        i_raw_w         <= '0;
        i_motor_stopped <= 1'b0;
        items_sent = 0;
        gaps_on    = 1'b1;
        center_u   = 2048;
        center_v   = 2048;
        center_w   = 2048;
        gain_steps[4] = GAIN_W'($urandom);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset gain. A stopped tick before any sample
        // accumulates the zero reset raw values; a running tick is dropped.
        send_item(CMD_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
        send_item(CMD_TICK, 12'h123, 12'h456, 12'h789, 1'b0);
        send_item(CMD_SAMPLE, 12'h000, 12'h000, 12'h000, 1'b0);
        send_item(CMD_SAMPLE, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
        send_item(CMD_SAMPLE, 12'hAAA, 12'h555, 12'h001, 1'b0);
        send_item(CMD_SAMPLE, 12'h555, 12'hAAA, 12'hFFE, 1'b1);

        // Each pass runs at one gain; the first keeps the reset value, the
        // rest cover max (saturation), zero, the smallest step, unity, random,
        // and back to the default.
        for (int phase = 0; phase <= 6; phase++) begin
            if (phase > 0) begin
                drain(SETTLE_CYCLES);
                write_gain(gain_steps[phase-1]);
                send_item(CMD_SAMPLE, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0);
                send_item(CMD_SAMPLE, 12'h000, 12'h001, 12'hFFF, 1'b1);
            end
            phase_end = items_sent + 235;
            while (items_sent < phase_end) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                act = $urandom_range(0, 99);
                if (act < 45) begin
                    // Calibration run: motor stopped, readings scattered
                    // around a new baseline, each followed by a stopped tick,
                    // sometimes with a running tick in between.
                    base_u = ($urandom_range(0, 1) == 1) ? $urandom_range(1900, 2200)
                                                         : $urandom_range(0, 4095);
                    base_v = ($urandom_range(0, 1) == 1) ? $urandom_range(1900, 2200)
                                                         : $urandom_range(0, 4095);
                    base_w = ($urandom_range(0, 1) == 1) ? $urandom_range(1900, 2200)
                                                         : $urandom_range(0, 4095);
                    for (int k = 0; k < CAL_SAMPLES; k++) begin
                        send_item(CMD_SAMPLE, pick_raw(base_u), pick_raw(base_v),
                                  pick_raw(base_w), logic'($urandom_range(0, 1)));
                        if ($urandom_range(0, 4) == 0)
                            send_item(CMD_TICK, RAW_W'($urandom), RAW_W'($urandom),
                                      RAW_W'($urandom), 1'b0);
                        send_item(CMD_TICK, RAW_W'($urandom), RAW_W'($urandom),
                                  RAW_W'($urandom), 1'b1);
                    end
                    center_u = base_u;
                    center_v = base_v;
                    center_w = base_w;
                end else if (act < 85) begin
                    // Running motor: samples around the learned offsets,
                    // with the odd dropped tick.
                    n = $urandom_range(15, 40);
                    repeat (n) begin
                        if ($urandom_range(0, 9) == 0)
                            send_item(CMD_TICK, RAW_W'($urandom), RAW_W'($urandom),
                                      RAW_W'($urandom), 1'b0);
                        else
                            send_item(CMD_SAMPLE, pick_raw(center_u), pick_raw(center_v),
                                      pick_raw(center_w), logic'($urandom_range(0, 1)));
                    end
                end else begin
                    // Noise: anything goes, which also breaks run alignment.
                    n = $urandom_range(3, 12);
                    repeat (n) send_random_item();
                end
                if ($urandom_range(0, 49) == 0) drain(0);
            end
        end

        drain(2 * SETTLE_CYCLES);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** phase_current_offset_calibrator_core: PASSED **");
        end else begin
            $display("** phase_current_offset_calibrator_core: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
